// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL of the instruction execute block.
// Each macro expands to one labelled concurrent assertion on clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the clock cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/sm83_pkg.sv -----
// Package for the instruction execute block: bus operation codes, flag bit
// positions and constants. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none
package sm83_pkg;
    localparam logic [2:0] BUS_NONE = 3'd0;
    localparam logic [2:0] BUS_RD8  = 3'd1;
    localparam logic [2:0] BUS_RD16 = 3'd2;
    localparam logic [2:0] BUS_WR8  = 3'd3;
    localparam logic [2:0] BUS_WR16 = 3'd4;
    localparam logic [15:0] HIGH_PAGE = 16'hff00;
    localparam int FZ = 3;
    localparam int FN = 2;
    localparam int FH = 1;
    localparam int FC = 0;
    localparam logic COMMAND_EXECUTE = 1'b0;
    localparam logic COMMAND_READ = 1'b1;
endpackage
`default_nettype wire

// ----- src/sm83_instruction_execute.sv -----
// Instruction execute block for the SM83 instruction set: top level.
// Depends on sm83_pkg and assert_macros.svh.
//
// Usage: words enter on the input channel (in_valid, in_stall) and each
// accepted word gives exactly one result word on the output channel
// (out_valid, out_stall). A word with command 0 issues an instruction;
// a word with command 1 returns data for a pending memory read.
// Decode, the ALU operation and register writeback are done in one pass
// between the input and result registers, and one word is accepted every
// cycle while the output does not stall. The input register is loaded
// while it is empty or its word moves on to the result register, which
// it does while that register is free or its word is being taken in the
// same cycle, so the block keeps streaming as long as the receiver keeps
// stall low. When the receiver stalls, the result register holds its
// word and in_stall rises only while input and result registers are full.
// Reset clears all architectural registers, the pending read and the valid
// flags of both pipeline registers; no word is produced until one is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sm83_instruction_execute (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        command,
    input  wire logic [7:0]  opcode,
    input  wire logic        cb_prefix,
    input  wire logic [15:0] immediate,
    input  wire logic [15:0] read_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       bus_op,
    output logic [15:0]      bus_address,
    output logic [15:0]      bus_write_data,
    output logic             done_res,
    output logic             status,
    output logic [15:0]      next_pc,
    output logic [7:0]       accumulator_out,
    output logic [3:0]       flags_out
);
    import sm83_pkg::*;

    logic        iv_reg;
    logic        cmd_reg, cbp_reg;
    logic [7:0]  op_reg;
    logic [15:0] imm_reg, rd_reg;

    logic [7:0]  a_reg, a_next;
    logic [3:0]  f_reg, f_next;
    logic [7:0]  gr_reg [6];
    logic [7:0]  gr_next [6];
    logic [15:0] sp_reg, sp_next, pc_reg, pc_next;
    logic [8:0]  pop_reg, pop_next;
    logic [15:0] pimm_reg, pimm_next;
    logic        aw_reg, aw_next;

    logic        ov_reg;
    logic [2:0]  bus_reg, bus_next;
    logic [15:0] addr_reg, addr_next, wd_reg, wd_next;
    logic        done_reg, done_next, st_reg, st_next;

    logic        fire, load;

    assign fire = iv_reg && (!ov_reg || !out_stall);
    assign in_stall = iv_reg && !fire;
    assign load = in_valid && !in_stall;

    function automatic logic [7:0] rd_r(input logic [2:0] i, input logic [7:0] a,
                                        input logic [7:0] g [6]);
        logic [7:0] r;
        case (i)
            3'd7: r = a;
            3'd6: r = 8'd0;
            default: r = g[i];
        endcase
        return r;
    endfunction

    function automatic logic cond_ok(input logic [1:0] c, input logic [3:0] f);
        logic r;
        case (c)
            2'd0: r = !f[FZ];
            2'd1: r = f[FZ];
            2'd2: r = !f[FC];
            default: r = f[FC];
        endcase
        return r;
    endfunction

    // ALU group: returns {flags, result}.
    function automatic logic [11:0] alu(input logic [2:0] sel, input logic [7:0] a,
                                        input logic [7:0] v, input logic [3:0] f);
        logic [8:0] r;
        logic [4:0] h;
        logic       c;
        logic [3:0] fo;
        c = f[FC];
        r = 9'd0;
        h = 5'd0;
        fo = 4'd0;
        case (sel)
            3'd0: begin
                r = {1'b0, a} + {1'b0, v};
                h = {1'b0, a[3:0]} + {1'b0, v[3:0]};
                fo = {r[7:0] == 8'd0, 1'b0, h[4], r[8]};
            end
            3'd1: begin
                r = {1'b0, a} + {1'b0, v} + {8'd0, c};
                h = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'd0, c};
                fo = {r[7:0] == 8'd0, 1'b0, h[4], r[8]};
            end
            3'd2, 3'd7: begin
                r = {1'b0, a} - {1'b0, v};
                h = {1'b0, a[3:0]} - {1'b0, v[3:0]};
                fo = {r[7:0] == 8'd0, 1'b1, h[4], r[8]};
            end
            3'd3: begin
                r = {1'b0, a} - {1'b0, v} - {8'd0, c};
                h = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'd0, c};
                fo = {r[7:0] == 8'd0, 1'b1, h[4], r[8]};
            end
            3'd4: begin
                r = {1'b0, a & v};
                fo = {r[7:0] == 8'd0, 3'b010};
            end
            3'd5: begin
                r = {1'b0, a ^ v};
                fo = {r[7:0] == 8'd0, 3'b000};
            end
            default: begin
                r = {1'b0, a | v};
                fo = {r[7:0] == 8'd0, 3'b000};
            end
        endcase
        if (sel == 3'd7) r[7:0] = a;
        return {fo, r[7:0]};
    endfunction

    // CB page: returns {flags, result}.
    function automatic logic [11:0] cbop(input logic [7:0] op, input logic [7:0] v,
                                         input logic [3:0] f);
        logic [7:0] r;
        logic       c;
        logic [3:0] fo;
        r = v;
        c = 1'b0;
        fo = f;
        case (op[7:6])
            2'd1: fo = {!v[op[5:3]], 1'b0, 1'b1, f[FC]};
            2'd2: r[op[5:3]] = 1'b0;
            2'd3: r[op[5:3]] = 1'b1;
            default: begin
                case (op[5:3])
                    3'd0: begin c = v[7]; r = {v[6:0], v[7]}; end
                    3'd1: begin c = v[0]; r = {v[0], v[7:1]}; end
                    3'd2: begin c = v[7]; r = {v[6:0], f[FC]}; end
                    3'd3: begin c = v[0]; r = {f[FC], v[7:1]}; end
                    3'd4: begin c = v[7]; r = {v[6:0], 1'b0}; end
                    3'd5: begin c = v[0]; r = {v[7], v[7:1]}; end
                    3'd6: begin c = 1'b0; r = {v[3:0], v[7:4]}; end
                    default: begin c = v[0]; r = {1'b0, v[7:1]}; end
                endcase
                fo = {r == 8'd0, 1'b0, 1'b0, c};
            end
        endcase
        return {fo, r};
    endfunction

    function automatic logic [1:0] op_len(input logic [7:0] op, input logic cbp);
        logic [1:0] x;
        logic [2:0] y, z;
        logic [1:0] l;
        x = op[7:6];
        y = op[5:3];
        z = op[2:0];
        l = 2'd1;
        if (x == 2'd0 && (z == 3'd6 || (z == 3'd0 && y >= 3'd3))) l = 2'd2;
        if (x == 2'd3 && (z == 3'd6 || (z == 3'd0 && y >= 3'd4))) l = 2'd2;
        if (op == 8'h08 || (x == 2'd0 && z == 3'd1 && !y[0])) l = 2'd3;
        if (x == 2'd3 && (z == 3'd4 || op == 8'hcd || op == 8'hc3 || op == 8'hea
            || op == 8'hfa || (z == 3'd2 && y < 3'd4))) l = 2'd3;
        if (x == 2'd3 && (z == 3'd7 || (z == 3'd3 && y != 3'd0)
            || (z == 3'd4 && y >= 3'd4) || (z == 3'd5 && y[0] && y != 3'd1))) l = 2'd0;
        if (op == 8'h10 || op == 8'h76 || op == 8'hcb || op == 8'hd9
            || op == 8'hf3 || op == 8'hfb) l = 2'd0;
        if (cbp) l = 2'd2;
        return l;
    endfunction

    logic [15:0] hl, bc, de;
    assign hl = {gr_reg[4], gr_reg[5]};
    assign bc = {gr_reg[0], gr_reg[1]};
    assign de = {gr_reg[2], gr_reg[3]};

    always_comb
    begin
        logic [1:0]  x, p, len;
        logic [2:0]  y, z;
        logic [7:0]  i8, v8, d8, rv;
        logic [15:0] rel, pr, adr, pcl, spo, stw;
        logic [11:0] res;
        logic [16:0] s17;
        logic [12:0] s13;
        logic [8:0]  s9, da;
        logic [4:0]  s5;
        logic        dc;

        a_next = a_reg;
        f_next = f_reg;
        gr_next = gr_reg;
        sp_next = sp_reg;
        pc_next = pc_reg;
        pop_next = pop_reg;
        pimm_next = pimm_reg;
        aw_next = aw_reg;
        bus_next = BUS_NONE;
        addr_next = 16'd0;
        wd_next = 16'd0;
        done_next = 1'b0;
        st_next = 1'b0;

        x = op_reg[7:6];
        y = op_reg[5:3];
        z = op_reg[2:0];
        p = y[2:1];
        i8 = imm_reg[7:0];
        rel = {{8{i8[7]}}, i8};
        len = op_len(op_reg, cbp_reg);
        pcl = pc_reg + {14'd0, len};
        rv = rd_r(z, a_reg, gr_reg);
        case (p)
            2'd0: pr = bc;
            2'd1: pr = de;
            2'd2: pr = hl;
            default: pr = sp_reg;
        endcase
        stw = (p == 2'd3) ? {a_reg, f_reg, 4'd0} : pr;
        s9 = {1'b0, sp_reg[7:0]} + {1'b0, i8};
        s5 = {1'b0, sp_reg[3:0]} + {1'b0, i8[3:0]};
        spo = sp_reg + rel;
        d8 = rd_reg[7:0];
        v8 = 8'd0;
        res = 12'd0;
        s17 = 17'd0;
        s13 = 13'd0;
        adr = 16'd0;
        da = 9'd0;
        dc = 1'b0;

        if (cmd_reg == COMMAND_EXECUTE) begin
            aw_next = 1'b0;
            done_next = 1'b1;
            if (len == 2'd0) begin
                st_next = 1'b1;
            end else begin
                pc_next = pcl;
                if (cbp_reg) begin
                    if (z == 3'd6) begin
                        aw_next = 1'b1; pop_next = {1'b1, op_reg}; pimm_next = imm_reg;
                        done_next = 1'b0; bus_next = BUS_RD8; addr_next = hl;
                    end else begin
                        res = cbop(op_reg, rv, f_reg);
                        f_next = res[11:8];
                        if (z == 3'd7) a_next = res[7:0];
                        else gr_next[z] = res[7:0];
                    end
                end else if (x == 2'd1 || x == 2'd2) begin
                    if (z == 3'd6) begin
                        aw_next = 1'b1; pop_next = {1'b0, op_reg}; pimm_next = imm_reg;
                        done_next = 1'b0; bus_next = BUS_RD8; addr_next = hl;
                    end else if (x == 2'd1) begin
                        if (y == 3'd6) begin
                            bus_next = BUS_WR8; addr_next = hl; wd_next = {8'd0, rv};
                        end else if (y == 3'd7) a_next = rv;
                        else gr_next[y] = rv;
                    end else begin
                        res = alu(y, a_reg, rv, f_reg);
                        a_next = res[7:0];
                        f_next = res[11:8];
                    end
                end else if (x == 2'd0) begin
                    case (z)
                        3'd0: begin
                            if (y == 3'd1) begin
                                bus_next = BUS_WR16; addr_next = imm_reg; wd_next = sp_reg;
                            end else if (y == 3'd3 || (y >= 3'd4 && cond_ok(y[1:0], f_reg)))
                                pc_next = pcl + rel;
                        end
                        3'd1: begin
                            if (!y[0]) begin
                                case (p)
                                    2'd0: begin gr_next[0] = imm_reg[15:8]; gr_next[1] = i8; end
                                    2'd1: begin gr_next[2] = imm_reg[15:8]; gr_next[3] = i8; end
                                    2'd2: begin gr_next[4] = imm_reg[15:8]; gr_next[5] = i8; end
                                    default: sp_next = imm_reg;
                                endcase
                            end else begin
                                s17 = {1'b0, hl} + {1'b0, pr};
                                s13 = {1'b0, hl[11:0]} + {1'b0, pr[11:0]};
                                f_next = {f_reg[FZ], 1'b0, s13[12], s17[16]};
                                gr_next[4] = s17[15:8];
                                gr_next[5] = s17[7:0];
                            end
                        end
                        3'd2: begin
                            adr = (p == 2'd0) ? bc : ((p == 2'd1) ? de : hl);
                            if (p == 2'd2) {gr_next[4], gr_next[5]} = hl + 16'd1;
                            if (p == 2'd3) {gr_next[4], gr_next[5]} = hl - 16'd1;
                            if (y[0]) begin
                                aw_next = 1'b1; pop_next = {1'b0, op_reg};
                                pimm_next = imm_reg; done_next = 1'b0;
                                bus_next = BUS_RD8; addr_next = adr;
                            end else begin
                                bus_next = BUS_WR8; addr_next = adr; wd_next = {8'd0, a_reg};
                            end
                        end
                        3'd3: begin
                            adr = y[0] ? pr - 16'd1 : pr + 16'd1;
                            case (p)
                                2'd0: {gr_next[0], gr_next[1]} = adr;
                                2'd1: {gr_next[2], gr_next[3]} = adr;
                                2'd2: {gr_next[4], gr_next[5]} = adr;
                                default: sp_next = adr;
                            endcase
                        end
                        3'd4, 3'd5: begin
                            if (y == 3'd6) begin
                                aw_next = 1'b1; pop_next = {1'b0, op_reg};
                                pimm_next = imm_reg; done_next = 1'b0;
                                bus_next = BUS_RD8; addr_next = hl;
                            end else begin
                                v8 = rd_r(y, a_reg, gr_reg);
                                if (z == 3'd4) begin
                                    v8 = v8 + 8'd1;
                                    f_next = {v8 == 8'd0, 1'b0, v8[3:0] == 4'd0, f_reg[FC]};
                                end else begin
                                    v8 = v8 - 8'd1;
                                    f_next = {v8 == 8'd0, 1'b1, v8[3:0] == 4'hf, f_reg[FC]};
                                end
                                if (y == 3'd7) a_next = v8;
                                else gr_next[y] = v8;
                            end
                        end
                        3'd6: begin
                            if (y == 3'd6) begin
                                bus_next = BUS_WR8; addr_next = hl; wd_next = {8'd0, i8};
                            end else if (y == 3'd7) a_next = i8;
                            else gr_next[y] = i8;
                        end
                        default: begin
                            case (y)
                                3'd0: begin a_next = {a_reg[6:0], a_reg[7]};
                                    f_next = {3'b000, a_reg[7]}; end
                                3'd1: begin a_next = {a_reg[0], a_reg[7:1]};
                                    f_next = {3'b000, a_reg[0]}; end
                                3'd2: begin a_next = {a_reg[6:0], f_reg[FC]};
                                    f_next = {3'b000, a_reg[7]}; end
                                3'd3: begin a_next = {f_reg[FC], a_reg[7:1]};
                                    f_next = {3'b000, a_reg[0]}; end
                                3'd4: begin
                                    da = {1'b0, a_reg};
                                    dc = f_reg[FC];
                                    if (f_reg[FN]) begin
                                        if (f_reg[FC]) da = da - 9'h060;
                                        if (f_reg[FH]) da = da - 9'h006;
                                    end else begin
                                        if (f_reg[FC] || a_reg > 8'h99) begin
                                            da = da + 9'h060; dc = 1'b1;
                                        end
                                        if (f_reg[FH] || a_reg[3:0] > 4'd9) da = da + 9'h006;
                                    end
                                    a_next = da[7:0];
                                    f_next = {da[7:0] == 8'd0, f_reg[FN], 1'b0, dc};
                                end
                                3'd5: begin a_next = ~a_reg;
                                    f_next = f_reg | 4'b0110; end
                                3'd6: f_next = {f_reg[FZ], 3'b001};
                                default: f_next = {f_reg[FZ], 2'b00, !f_reg[FC]};
                            endcase
                        end
                    endcase
                end else begin
                    case (z)
                        3'd0: begin
                            if (y < 3'd4) begin
                                if (cond_ok(y[1:0], f_reg)) begin
                                    aw_next = 1'b1; pop_next = {1'b0, op_reg};
                                    pimm_next = imm_reg; done_next = 1'b0;
                                    bus_next = BUS_RD16; addr_next = sp_reg;
                                end
                            end else if (y == 3'd4) begin
                                bus_next = BUS_WR8; addr_next = HIGH_PAGE | {8'd0, i8};
                                wd_next = {8'd0, a_reg};
                            end else if (y == 3'd6) begin
                                aw_next = 1'b1; pop_next = {1'b0, op_reg};
                                pimm_next = imm_reg; done_next = 1'b0;
                                bus_next = BUS_RD8; addr_next = HIGH_PAGE | {8'd0, i8};
                            end else begin
                                f_next = {2'b00, s5[4], s9[8]};
                                if (y == 3'd5) sp_next = spo;
                                else {gr_next[4], gr_next[5]} = spo;
                            end
                        end
                        3'd1: begin
                            if (!y[0] || p == 2'd0) begin
                                aw_next = 1'b1; pop_next = {1'b0, op_reg};
                                pimm_next = imm_reg; done_next = 1'b0;
                                bus_next = BUS_RD16; addr_next = sp_reg;
                            end else if (p == 2'd2) pc_next = hl;
                            else sp_next = hl;
                        end
                        3'd2: begin
                            if (y < 3'd4) begin
                                if (cond_ok(y[1:0], f_reg)) pc_next = imm_reg;
                            end else if (y == 3'd4) begin
                                bus_next = BUS_WR8; addr_next = HIGH_PAGE | {8'd0, gr_reg[1]};
                                wd_next = {8'd0, a_reg};
                            end else if (y == 3'd5) begin
                                bus_next = BUS_WR8; addr_next = imm_reg;
                                wd_next = {8'd0, a_reg};
                            end else begin
                                aw_next = 1'b1; pop_next = {1'b0, op_reg};
                                pimm_next = imm_reg; done_next = 1'b0;
                                bus_next = BUS_RD8;
                                addr_next = (y == 3'd6) ? (HIGH_PAGE | {8'd0, gr_reg[1]})
                                                        : imm_reg;
                            end
                        end
                        3'd3: pc_next = imm_reg;
                        3'd4, 3'd5: begin
                            if (z == 3'd5 && !y[0]) begin
                                sp_next = sp_reg - 16'd2;
                                bus_next = BUS_WR16; addr_next = sp_reg - 16'd2;
                                wd_next = stw;
                            end else if (z == 3'd5 || cond_ok(y[1:0], f_reg)) begin
                                sp_next = sp_reg - 16'd2;
                                bus_next = BUS_WR16; addr_next = sp_reg - 16'd2;
                                wd_next = pcl;
                                pc_next = imm_reg;
                            end
                        end
                        default: begin
                            res = alu(y, a_reg, i8, f_reg);
                            a_next = res[7:0];
                            f_next = res[11:8];
                        end
                    endcase
                end
            end
        end else if (aw_reg) begin
            aw_next = 1'b0;
            done_next = 1'b1;
            x = pop_reg[7:6];
            y = pop_reg[5:3];
            z = pop_reg[2:0];
            if (pop_reg[8]) begin
                res = cbop(pop_reg[7:0], d8, f_reg);
                f_next = res[11:8];
                if (x != 2'd1) begin
                    bus_next = BUS_WR8; addr_next = hl; wd_next = {8'd0, res[7:0]};
                end
            end else if (pop_reg[7:0] == 8'h34) begin
                v8 = d8 + 8'd1;
                f_next = {v8 == 8'd0, 1'b0, v8[3:0] == 4'd0, f_reg[FC]};
                bus_next = BUS_WR8; addr_next = hl; wd_next = {8'd0, v8};
            end else if (pop_reg[7:0] == 8'h35) begin
                v8 = d8 - 8'd1;
                f_next = {v8 == 8'd0, 1'b1, v8[3:0] == 4'hf, f_reg[FC]};
                bus_next = BUS_WR8; addr_next = hl; wd_next = {8'd0, v8};
            end else if (x == 2'd1) begin
                if (y == 3'd7) a_next = d8;
                else if (y != 3'd6) gr_next[y] = d8;
            end else if (x == 2'd2) begin
                res = alu(y, a_reg, d8, f_reg);
                a_next = res[7:0];
                f_next = res[11:8];
            end else if (x == 2'd3 && ((z == 3'd0 && y < 3'd4) || pop_reg[7:0] == 8'hc9)) begin
                pc_next = rd_reg;
                sp_next = sp_reg + 16'd2;
            end else if (x == 2'd3 && z == 3'd1) begin
                case (y[2:1])
                    2'd0: {gr_next[0], gr_next[1]} = rd_reg;
                    2'd1: {gr_next[2], gr_next[3]} = rd_reg;
                    2'd2: {gr_next[4], gr_next[5]} = rd_reg;
                    default: begin a_next = rd_reg[15:8]; f_next = rd_reg[7:4]; end
                endcase
                sp_next = sp_reg + 16'd2;
            end else begin
                a_next = d8;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            iv_reg <= 1'b0;
            ov_reg <= 1'b0;
            a_reg <= 8'd0;
            f_reg <= 4'd0;
            for (int i = 0; i < 6; i++) gr_reg[i] <= 8'd0;
            sp_reg <= 16'd0;
            pc_reg <= 16'd0;
            pop_reg <= 9'd0;
            pimm_reg <= 16'd0;
            aw_reg <= 1'b0;
        end else begin
            if (load) iv_reg <= 1'b1;
            else if (fire) iv_reg <= 1'b0;
            if (fire) ov_reg <= 1'b1;
            else if (!out_stall) ov_reg <= 1'b0;
            if (fire) begin
                a_reg <= a_next;
                f_reg <= f_next;
                gr_reg <= gr_next;
                sp_reg <= sp_next;
                pc_reg <= pc_next;
                pop_reg <= pop_next;
                pimm_reg <= pimm_next;
                aw_reg <= aw_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            cmd_reg <= command;
            op_reg <= opcode;
            cbp_reg <= cb_prefix;
            imm_reg <= immediate;
            rd_reg <= read_data;
        end
        if (fire) begin
            bus_reg <= bus_next;
            addr_reg <= addr_next;
            wd_reg <= wd_next;
            done_reg <= done_next;
            st_reg <= st_next;
        end
    end

    assign out_valid = ov_reg;
    assign bus_op = bus_reg;
    assign bus_address = addr_reg;
    assign bus_write_data = wd_reg;
    assign done_res = done_reg;
    assign status = st_reg;
    assign next_pc = pc_reg;
    assign accumulator_out = a_reg;
    assign flags_out = f_reg;

    `ASSERT_NEXT(a_fire_valid, fire, out_valid)
    `ASSERT_IMPLY(a_status_done, out_valid && status, done_res && bus_op == BUS_NONE)
    `ASSERT_IMPLY(a_wait_read, out_valid && !done_res && status == 1'b0
        && bus_op != BUS_NONE, bus_op == BUS_RD8 || bus_op == BUS_RD16)
    `ASSERT_IMPLY(a_stall_full, in_stall, iv_reg && ov_reg)
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for sm83_instruction_execute: a queue-fed driver, a monitor and
// an in-file predictor of the instruction set. It depends on sm83_pkg and the block's RTL.
`timescale 1ns / 1ps
module tb;
    import sm83_pkg::*;

    typedef struct {
        bit        cmd;
        bit [7:0]  op;
        bit        cb;
        bit [15:0] imm;
        bit [15:0] rdata;
        bit        hold;
    } word_t;

    typedef struct packed {
        logic [2:0]  bus;
        logic [15:0] addr;
        logic [15:0] wdata;
        logic        done;
        logic        stat;
        logic [15:0] pc;
        logic [7:0]  acc;
        logic [3:0]  flg;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        command = COMMAND_EXECUTE;
    logic [7:0]  opcode = '0;
    logic        cb_prefix = 1'b0;
    logic [15:0] immediate = '0;
    logic [15:0] read_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  bus_op;
    logic [15:0] bus_address;
    logic [15:0] bus_write_data;
    logic        done_res;
    logic        status;
    logic [15:0] next_pc;
    logic [7:0]  accumulator_out;
    logic [3:0]  flags_out;

    word_t   stimulus_words[$];
    result_t expected_results[$];
    int      failures = 0;
    int      idle_cycles = 0;
    int      send_gap = 0;
    int      take_gap = 0;

    // Predicted architectural state.
    bit [7:0]  acc_reg;
    bit [3:0]  flag_reg;
    bit [7:0]  gp_reg[6];
    bit [15:0] sp_reg;
    bit [15:0] pc_reg;
    bit [8:0]  parked_op;
    bit        parked;
    bit [2:0]  r_bus;
    bit [15:0] r_addr;
    bit [15:0] r_wdata;
    bit        r_done;
    bit        r_stat;

    sm83_instruction_execute DUT (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void set_flags(bit z, bit n, bit h, bit c);
        flag_reg = {z, n, h, c};
    endfunction

    function automatic int unsigned get_r8(int unsigned i);
        if (i == 7) return acc_reg;
        if (i == 6) return 0;
        return gp_reg[i];
    endfunction

    function automatic void put_r8(int unsigned i, int unsigned v);
        if (i == 7) acc_reg = v[7:0];
        else if (i != 6) gp_reg[i] = v[7:0];
    endfunction

    function automatic int unsigned get_r16(int unsigned p);
        if (p == 3) return sp_reg;
        return {gp_reg[2 * p], gp_reg[2 * p + 1]};
    endfunction

    function automatic void put_r16(int unsigned p, int unsigned w);
        if (p == 3) sp_reg = w[15:0];
        else
        begin
            gp_reg[2 * p] = w[15:8];
            gp_reg[2 * p + 1] = w[7:0];
        end
    endfunction

    function automatic bit condition_met(int unsigned c);
        case (c & 3)
            0: return !flag_reg[FZ];
            1: return flag_reg[FZ];
            2: return !flag_reg[FC];
            default: return flag_reg[FC];
        endcase
    endfunction

    function automatic void drive_bus(bit [2:0] kind, int unsigned a, int unsigned d);
        r_bus = kind;
        r_addr = a[15:0];
        r_wdata = d[15:0];
    endfunction

    function automatic void start_read(int unsigned op9, bit [2:0] kind, int unsigned a);
        parked_op = op9[8:0];
        parked = 1'b1;
        r_done = 1'b0;
        drive_bus(kind, a, 0);
    endfunction

    function automatic int unsigned increment8(int unsigned v);
        int unsigned r;
        r = (v + 1) & 8'hff;
        set_flags(r == 0, 0, (v & 4'hf) == 4'hf, flag_reg[FC]);
        return r;
    endfunction

    function automatic int unsigned decrement8(int unsigned v);
        int unsigned r;
        r = (v - 1) & 8'hff;
        set_flags(r == 0, 1, (v & 4'hf) == 0, flag_reg[FC]);
        return r;
    endfunction

    function automatic void arith(int unsigned sel, int unsigned v);
        int unsigned a, c, r;
        a = acc_reg;
        c = flag_reg[FC];
        case (sel & 7)
            0:
            begin
                r = a + v;
                set_flags((r & 8'hff) == 0, 0, (a & 15) + (v & 15) > 15, r > 255);
            end
            1:
            begin
                r = a + v + c;
                set_flags((r & 8'hff) == 0, 0, (a & 15) + (v & 15) + c > 15, r > 255);
            end
            2, 7:
            begin
                r = (a - v) & 8'hff;
                set_flags(r == 0, 1, (v & 15) > (a & 15), v > a);
            end
            3:
            begin
                r = (a - v - c) & 8'hff;
                set_flags(r == 0, 1, (v & 15) + c > (a & 15), v + c > a);
            end
            4:
            begin
                r = a & v;
                set_flags(r == 0, 0, 1, 0);
            end
            5:
            begin
                r = a ^ v;
                set_flags(r == 0, 0, 0, 0);
            end
            default:
            begin
                r = a | v;
                set_flags(r == 0, 0, 0, 0);
            end
        endcase
        if ((sel & 7) != 7) acc_reg = r[7:0];
    endfunction

    function automatic int unsigned bit_page(int unsigned op, int unsigned v);
        int unsigned grp, sel, r, c;
        grp = (op >> 6) & 3;
        sel = (op >> 3) & 7;
        if (grp == 1)
        begin
            set_flags(((v >> sel) & 1) == 0, 0, 1, flag_reg[FC]);
            return v;
        end
        if (grp == 2) return v & ~(1 << sel) & 8'hff;
        if (grp == 3) return (v | (1 << sel)) & 8'hff;
        case (sel)
            0: begin c = v >> 7; r = (v << 1) | c; end
            1: begin c = v & 1; r = (v >> 1) | (c << 7); end
            2: begin c = v >> 7; r = (v << 1) | flag_reg[FC]; end
            3: begin c = v & 1; r = (v >> 1) | (flag_reg[FC] << 7); end
            4: begin c = v >> 7; r = v << 1; end
            5: begin c = v & 1; r = (v >> 1) | (v & 8'h80); end
            6: begin c = 0; r = ((v & 15) << 4) | (v >> 4); end
            default: begin c = v & 1; r = v >> 1; end
        endcase
        r &= 8'hff;
        set_flags(r == 0, 0, 0, c);
        return r;
    endfunction

    function automatic void decimal_adjust();
        int unsigned a, c;
        a = acc_reg;
        c = flag_reg[FC];
        if (flag_reg[FN])
        begin
            if (c) a -= 8'h60;
            if (flag_reg[FH]) a -= 6;
        end
        else
        begin
            if (c || a > 8'h99)
            begin
                a += 8'h60;
                c = 1;
            end
            if (flag_reg[FH] || (acc_reg & 15) > 9) a += 6;
        end
        acc_reg = a[7:0];
        set_flags(acc_reg == 0, flag_reg[FN], 0, c);
    endfunction

    function automatic int unsigned stack_offset(int unsigned e);
        int unsigned s, off;
        s = sp_reg;
        off = (e & 8'h80) ? (e | 16'hff00) : e;
        set_flags(0, 0, (s & 15) + (e & 15) > 15, (s & 8'hff) + e > 8'hff);
        return (s + off) & 16'hffff;
    endfunction

    function automatic int unsigned length_of(int unsigned op, bit cbp);
        int unsigned x, y, z;
        x = op >> 6;
        y = (op >> 3) & 7;
        z = op & 7;
        if (cbp) return 2;
        if (op == 8'h10 || op == 8'h76 || op == 8'hcb || op == 8'hd9 || op == 8'hf3
            || op == 8'hfb) return 0;
        if (x == 3 && (z == 7 || (z == 3 && y != 0) || (z == 4 && y >= 4)
            || (z == 5 && y[0] && y != 1))) return 0;
        if (op == 8'h08 || (x == 0 && z == 1 && !y[0])) return 3;
        if (x == 3 && (z == 4 || op == 8'hcd || op == 8'hc3 || op == 8'hea || op == 8'hfa
            || (z == 2 && y < 4))) return 3;
        if (x == 0 && (z == 6 || (z == 0 && y >= 3))) return 2;
        if (x == 3 && (z == 6 || (z == 0 && y >= 4))) return 2;
        return 1;
    endfunction

    function automatic void run_instruction(int unsigned op, bit cbp, int unsigned imm);
        int unsigned x, y, z, p, e, hl, len, rel, a, w, s;
        x = op >> 6;
        y = (op >> 3) & 7;
        z = op & 7;
        p = y >> 1;
        e = imm & 8'hff;
        hl = get_r16(2);
        len = length_of(op, cbp);
        rel = (e & 8'h80) ? (e | 16'hff00) : e;
        r_done = 1'b1;
        if (len == 0)
        begin
            r_stat = 1'b1;
            return;
        end
        pc_reg = pc_reg + len[15:0];
        if (cbp)
        begin
            if (z == 6) start_read(9'h100 | op, BUS_RD8, hl);
            else put_r8(z, bit_page(op, get_r8(z)));
            return;
        end
        if (x == 1)
        begin
            if (z == 6) start_read(op, BUS_RD8, hl);
            else if (y == 6) drive_bus(BUS_WR8, hl, get_r8(z));
            else put_r8(y, get_r8(z));
            return;
        end
        if (x == 2)
        begin
            if (z == 6) start_read(op, BUS_RD8, hl);
            else arith(y, get_r8(z));
            return;
        end
        if (x == 0)
        begin
            case (z)
                0:
                    if (y == 1) drive_bus(BUS_WR16, imm, sp_reg);
                    else if (y == 3 || (y >= 4 && condition_met(y - 4)))
                        pc_reg = pc_reg + rel[15:0];
                1:
                    if (!y[0]) put_r16(p, imm);
                    else
                    begin
                        w = get_r16(p);
                        s = hl + w;
                        set_flags(flag_reg[FZ], 0, (hl & 12'hfff) + (w & 12'hfff) > 12'hfff,
                                  s > 16'hffff);
                        put_r16(2, s);
                    end
                2:
                begin
                    a = (p < 2) ? get_r16(p) : hl;
                    if (p == 2) put_r16(2, hl + 1);
                    if (p == 3) put_r16(2, hl - 1);
                    if (y[0]) start_read(op, BUS_RD8, a);
                    else drive_bus(BUS_WR8, a, acc_reg);
                end
                3: put_r16(p, y[0] ? get_r16(p) - 1 : get_r16(p) + 1);
                4, 5:
                    if (y == 6) start_read(op, BUS_RD8, hl);
                    else put_r8(y, z == 4 ? increment8(get_r8(y)) : decrement8(get_r8(y)));
                6:
                    if (y == 6) drive_bus(BUS_WR8, hl, e);
                    else put_r8(y, e);
                default:
                begin
                    a = acc_reg;
                    case (y)
                        0: begin acc_reg = {a[6:0], a[7]}; set_flags(0, 0, 0, a[7]); end
                        1: begin acc_reg = {a[0], a[7:1]}; set_flags(0, 0, 0, a[0]); end
                        2:
                        begin
                            acc_reg = {a[6:0], flag_reg[FC]};
                            set_flags(0, 0, 0, a[7]);
                        end
                        3:
                        begin
                            acc_reg = {flag_reg[FC], a[7:1]};
                            set_flags(0, 0, 0, a[0]);
                        end
                        4: decimal_adjust();
                        5:
                        begin
                            acc_reg = ~a[7:0];
                            flag_reg[FN] = 1'b1;
                            flag_reg[FH] = 1'b1;
                        end
                        6: set_flags(flag_reg[FZ], 0, 0, 1);
                        default: set_flags(flag_reg[FZ], 0, 0, !flag_reg[FC]);
                    endcase
                end
            endcase
            return;
        end
        case (z)
            0:
                if (y < 4)
                begin
                    if (condition_met(y)) start_read(op, BUS_RD16, sp_reg);
                end
                else if (y == 4) drive_bus(BUS_WR8, HIGH_PAGE | e, acc_reg);
                else if (y == 5) sp_reg = stack_offset(e);
                else if (y == 6) start_read(op, BUS_RD8, HIGH_PAGE | e);
                else put_r16(2, stack_offset(e));
            1:
                if (!y[0] || p == 0) start_read(op, BUS_RD16, sp_reg);
                else if (p == 2) pc_reg = hl;
                else sp_reg = hl;
            2:
                if (y < 4)
                begin
                    if (condition_met(y)) pc_reg = imm;
                end
                else if (y == 4) drive_bus(BUS_WR8, HIGH_PAGE | gp_reg[1], acc_reg);
                else if (y == 5) drive_bus(BUS_WR8, imm, acc_reg);
                else if (y == 6) start_read(op, BUS_RD8, HIGH_PAGE | gp_reg[1]);
                else start_read(op, BUS_RD8, imm);
            3: pc_reg = imm;
            4, 5:
                if (z == 5 && !y[0])
                begin
                    sp_reg = sp_reg - 2;
                    drive_bus(BUS_WR16, sp_reg,
                              p == 3 ? {acc_reg, flag_reg, 4'h0} : get_r16(p));
                end
                else if (z == 5 || condition_met(y))
                begin
                    sp_reg = sp_reg - 2;
                    drive_bus(BUS_WR16, sp_reg, pc_reg);
                    pc_reg = imm;
                end
            default: arith(y, e);
        endcase
    endfunction

    function automatic void complete_read(int unsigned data);
        int unsigned op, d, x, y, z, hl, r;
        op = parked_op[7:0];
        d = data & 8'hff;
        x = op >> 6;
        y = (op >> 3) & 7;
        z = op & 7;
        hl = get_r16(2);
        parked = 1'b0;
        r_done = 1'b1;
        if (parked_op[8])
        begin
            r = bit_page(op, d);
            if (x != 1) drive_bus(BUS_WR8, hl, r);
        end
        else if (op == 8'h34) drive_bus(BUS_WR8, hl, increment8(d));
        else if (op == 8'h35) drive_bus(BUS_WR8, hl, decrement8(d));
        else if (x == 1) put_r8(y, d);
        else if (x == 2) arith(y, d);
        else if (x == 3 && ((z == 0 && y < 4) || op == 8'hc9))
        begin
            pc_reg = data;
            sp_reg = sp_reg + 2;
        end
        else if (x == 3 && z == 1)
        begin
            if ((y >> 1) == 3)
            begin
                acc_reg = data[15:8];
                flag_reg = data[7:4];
            end
            else put_r16(y >> 1, data);
            sp_reg = sp_reg + 2;
        end
        else acc_reg = d;
    endfunction

    function automatic result_t predict_word(word_t wd);
        result_t res;
        r_bus = BUS_NONE;
        r_addr = '0;
        r_wdata = '0;
        r_done = 1'b0;
        r_stat = 1'b0;
        if (wd.cmd == COMMAND_EXECUTE)
        begin
            parked = 1'b0;
            run_instruction(wd.op, wd.cb, wd.imm);
        end
        else if (parked) complete_read(wd.rdata);
        res = '{r_bus, r_addr, r_wdata, r_done, r_stat, pc_reg, acc_reg, flag_reg};
        return res;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("%0t: %s is %h, expected %h", $realtime, what, got, want);
        failures++;
    endtask

    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic add_word(bit cmd, bit [7:0] op, bit cb, bit [15:0] imm, bit [15:0] rd);
        word_t wd;
        wd = '{cmd, op, cb, imm, rd, 1'b0};
        stimulus_words.push_back(wd);
    endtask

    always @(posedge clk)
    begin
        word_t   wd;
        result_t res;
        bit      next_valid;
        if (rst_n)
        begin
            next_valid = in_valid;
            if (in_valid && !in_stall)
            begin
                res = predict_word('{command, opcode, cb_prefix, immediate, read_data, 1'b0});
                expected_results.push_back(res);
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_gap > 0) send_gap--;
                else if (stimulus_words.size() != 0
                         && !(stimulus_words[0].hold && expected_results.size() != 0))
                begin
                    wd = stimulus_words.pop_front();
                    command <= wd.cmd;
                    opcode <= wd.op;
                    cb_prefix <= wd.cb;
                    immediate <= wd.imm;
                    read_data <= wd.rdata;
                    next_valid = 1'b1;
                    send_gap = pick_gap();
                end
            end
            in_valid <= next_valid;
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result word with nothing expected", $realtime);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (bus_op !== want.bus) report_mismatch("bus_op", bus_op, want.bus);
                    if (bus_address !== want.addr)
                        report_mismatch("bus_address", bus_address, want.addr);
                    if (bus_write_data !== want.wdata)
                        report_mismatch("bus_write_data", bus_write_data, want.wdata);
                    if (done_res !== want.done) report_mismatch("done_res", done_res, want.done);
                    if (status !== want.stat) report_mismatch("status", status, want.stat);
                    if (next_pc !== want.pc) report_mismatch("next_pc", next_pc, want.pc);
                    if (accumulator_out !== want.acc)
                        report_mismatch("accumulator_out", accumulator_out, want.acc);
                    if (flags_out !== want.flg) report_mismatch("flags_out", flags_out, want.flg);
                end
            end
            if (take_gap > 0)
            begin
                take_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                take_gap = pick_gap();
                out_stall <= 1'b0;
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= 4000)
            begin
                $display("sm83_instruction_execute verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int     count;
        bit     cbp;
        bit [7:0] op;
        word_t  wd;
        acc_reg = '0;
        flag_reg = '0;
        foreach (gp_reg[i]) gp_reg[i] = '0;
        sp_reg = '0;
        pc_reg = '0;
        parked_op = '0;
        parked = 1'b0;

        add_word(COMMAND_READ, 8'h00, 0, 16'h0000, 16'hffff);
        add_word(COMMAND_EXECUTE, 8'h00, 0, 16'h0000, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'h3e, 0, 16'hffff, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'hc6, 0, 16'h0001, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'h27, 0, 16'h0000, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'hde, 0, 16'h00ff, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'h27, 0, 16'h0000, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'h2f, 0, 16'h0000, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'h37, 0, 16'h0000, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'h17, 0, 16'h0000, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'h0f, 0, 16'h0000, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'h21, 0, 16'hffff, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'h34, 0, 16'h0000, 16'h0000);
        add_word(COMMAND_READ, 8'h00, 0, 16'h0000, 16'h00ff);
        add_word(COMMAND_EXECUTE, 8'h35, 0, 16'h0000, 16'h0000);
        add_word(COMMAND_READ, 8'h00, 0, 16'h0000, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'h06, 1, 16'h0000, 16'h0000);
        add_word(COMMAND_READ, 8'h00, 0, 16'h0000, 16'h0080);
        add_word(COMMAND_EXECUTE, 8'h7f, 1, 16'h0000, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'hff, 1, 16'h0000, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'h31, 0, 16'hfffe, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'hf5, 0, 16'h0000, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'hf1, 0, 16'h0000, 16'h0000);
        add_word(COMMAND_READ, 8'h00, 0, 16'h0000, 16'hffff);
        add_word(COMMAND_EXECUTE, 8'hcd, 0, 16'h8000, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'hc9, 0, 16'h0000, 16'h0000);
        add_word(COMMAND_READ, 8'h00, 0, 16'h0000, 16'h1234);
        add_word(COMMAND_EXECUTE, 8'h18, 0, 16'h0080, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'hf8, 0, 16'h007f, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'h10, 0, 16'h0000, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'hcb, 0, 16'h0000, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'h7e, 0, 16'h0000, 16'h0000);
        add_word(COMMAND_EXECUTE, 8'hd3, 0, 16'h0000, 16'h0000);

        count = 0;
        while (count < 950)
        begin
            cbp = ($urandom_range(0, 3) == 0);
            op = $urandom_range(0, 255);
            wd = '{COMMAND_EXECUTE, op, cbp, 16'($urandom), 16'($urandom),
                   count == 450 || count == 451};
            stimulus_words.push_back(wd);
            count++;
            if ($urandom_range(0, 99) < 75)
            begin
                add_word(COMMAND_READ, 8'($urandom), $urandom_range(0, 1), 16'($urandom),
                         16'($urandom));
                count++;
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        while (stimulus_words.size() != 0 || in_valid) @(posedge clk);
        while (expected_results.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (failures == 0)
            $display("sm83_instruction_execute verification clean");
        else
            $display("sm83_instruction_execute verification failed");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+src
src/sm83_pkg.sv
src/sm83_instruction_execute.sv
tb/tb.sv
